// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define CHK_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// File: rtl/avbt_pkg.sv
// Package for the affine vector and box transform: opcodes, payload types, constants.
// No dependencies.
`default_nettype none
package avbt_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    OP_LOAD_FWD = 3'd0,
    OP_LOAD_INV = 3'd1,
    OP_POINT    = 3'd2,
    OP_DIR      = 3'd3,
    OP_INV_POINT = 3'd4,
    OP_INV_DIR  = 3'd5,
    OP_BOX      = 3'd6,
    OP_NONE     = 3'd7
  } op_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [1:0]         row_index;
    logic [1:0]         col_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
    logic signed [31:0] off_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } out_t;

  // Work for the back end: selected 3x4 matrix, vector, extents, flags.
  typedef struct packed {
    logic signed [2:0][3:0][31:0] m;
    logic signed [2:0][31:0]      v;
    logic signed [2:0][31:0]      o;
    logic                         add_t;
    logic                         box;
  } job_t;
endpackage
`default_nettype wire

// File: rtl/avbt_front.sv
// Front end: holds both matrices, applies loads and selects coefficients for transforms.
// Depends on avbt_pkg.
`default_nettype none
module avbt_front (
  input  wire             clk,
  input  wire             rst,
  input  wire             valid,
  output logic            stall,
  input  avbt_pkg::in_t   data,
  output logic            job_valid,
  input  wire             job_stall,
  output avbt_pkg::job_t  job
);
  import avbt_pkg::*;

  logic signed [2:0][3:0][31:0] fwd;
  logic signed [2:0][3:0][31:0] inv;
  logic accept;
  logic is_xf;
  job_t j;

  assign stall = job_stall;
  assign accept = valid && !stall;
  assign is_xf = (data.opcode inside {OP_POINT, OP_DIR, OP_INV_POINT, OP_INV_DIR, OP_BOX});
  assign job_valid = valid && is_xf;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= '0;
      inv <= '0;
    end else if (accept && data.row_index != 2'd3) begin
      if (data.opcode == OP_LOAD_FWD) fwd[data.row_index][data.col_index] <= data.coef_value;
      if (data.opcode == OP_LOAD_INV) inv[data.row_index][data.col_index] <= data.coef_value;
    end
  end

  always_comb begin
    j.v = {data.in_z, data.in_y, data.in_x};
    j.o = {data.off_z, data.off_y, data.off_x};
    j.box = (data.opcode == OP_BOX);
    j.add_t = (data.opcode inside {OP_POINT, OP_INV_POINT, OP_BOX});
    j.m = fwd;
    if (data.opcode == OP_INV_POINT) j.m = inv;
    if (data.opcode == OP_INV_DIR) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) j.m[r][c] = fwd[c][r];
        j.m[r][3] = '0;
      end
    end
  end
  assign job = j;
endmodule
`default_nettype wire

// File: rtl/avbt_queue.sv
// Short queue of jobs between front and back end.
// Depends on avbt_pkg.
`default_nettype none
module avbt_queue (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  input  avbt_pkg::job_t  in_job,
  output logic            out_valid,
  input  wire             out_stall,
  output avbt_pkg::job_t  out_job
);
  import avbt_pkg::*;

  job_t mem [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp, rp;
  logic [$clog2(QDEPTH):0] cnt;
  logic push, pop;

  assign in_stall = (cnt == QDEPTH[$clog2(QDEPTH):0]);
  assign out_valid = (cnt != '0);
  assign out_job = mem[rp];
  assign push = in_valid && !in_stall;
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + {{$clog2(QDEPTH){1'b0}}, push} - {{$clog2(QDEPTH){1'b0}}, pop};
    end
  end
endmodule
`default_nettype wire

// File: rtl/avbt_back.sv
// Back end: two-stage pipeline of products, then sums, saturation and output register.
// Depends on avbt_pkg.
`default_nettype none
module avbt_back #(
  parameter int FRAC_BITS = avbt_pkg::FRAC_BITS_DEF
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             job_valid,
  output logic            job_stall,
  input  avbt_pkg::job_t  job,
  output logic            valid,
  input  wire             stall,
  output avbt_pkg::out_t  data
);
  import avbt_pkg::*;

  localparam int PW = 64 - FRAC_BITS;

  logic s1_valid;
  logic s1_box;
  logic signed [2:0][2:0][PW-1:0] pc, pe;
  logic signed [2:0][31:0] tr;
  logic adv1, adv2;
  logic signed [2:0][PW+1:0] c_s, e_s;
  out_t o_next;

  assign adv2 = !valid || !stall;
  assign adv1 = !s1_valid || adv2;
  assign job_stall = !adv1;

  function automatic logic signed [31:0] sat(input logic signed [PW+2:0] x);
    if (x > 2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (adv1) s1_valid <= job_valid;
  end

  always_ff @(posedge clk) begin
    logic signed [63:0] p;
    if (adv1) begin
      s1_box <= job.box;
      for (int r = 0; r < 3; r++) begin
        tr[r] <= job.add_t ? job.m[r][3] : 32'sd0;
        for (int c = 0; c < 3; c++) begin
          p = $signed(job.v[c]) * $signed(job.m[r][c]);
          pc[r][c] <= p[63:FRAC_BITS];
          p = $signed(job.o[c]) * $signed(job.m[r][c]);
          pe[r][c] <= p[63] ? -p[63:FRAC_BITS] : p[63:FRAC_BITS];
        end
      end
    end
  end

  always_comb begin
    o_next = '0;
    for (int r = 0; r < 3; r++) begin
      c_s[r] = {{2{pc[r][0][PW-1]}}, pc[r][0]} + {{2{pc[r][1][PW-1]}}, pc[r][1]}
             + {{2{pc[r][2][PW-1]}}, pc[r][2]} + {{(PW+2-32){tr[r][31]}}, tr[r]};
      e_s[r] = {2'b00, pe[r][0]} + {2'b00, pe[r][1]} + {2'b00, pe[r][2]};
      if (!s1_box) e_s[r] = '0;
    end
    o_next.res_x = sat({c_s[0][PW+1], c_s[0]} - {e_s[0][PW+1], e_s[0]});
    o_next.res_y = sat({c_s[1][PW+1], c_s[1]} - {e_s[1][PW+1], e_s[1]});
    o_next.res_z = sat({c_s[2][PW+1], c_s[2]} - {e_s[2][PW+1], e_s[2]});
    if (s1_box) begin
      o_next.max_x = sat({c_s[0][PW+1], c_s[0]} + {e_s[0][PW+1], e_s[0]});
      o_next.max_y = sat({c_s[1][PW+1], c_s[1]} + {e_s[1][PW+1], e_s[1]});
      o_next.max_z = sat({c_s[2][PW+1], c_s[2]} + {e_s[2][PW+1], e_s[2]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (adv2) valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) data <= o_next;
  end
endmodule
`default_nettype wire

// File: rtl/affine_vector_and_box_transform_top.sv
// Top level of the affine vector and box transform.
// Depends on avbt_pkg, avbt_front, avbt_queue and avbt_back.
//
// Requests enter on valid/stall with one in_t payload. Load requests write one
// coefficient of the forward or inverse 3x4 matrix and give no result; transform
// requests give one out_t result on the output channel. One request is accepted
// per cycle while in_stall is low. The front end stores loads and selects the matrix,
// a two-entry queue decouples it from the back end, and the back end forms the centre
// and extent products in one registered stage and sums and saturates into the output
// register. An accepted transform passes through the queue, the product stage and
// the output register. Throughput is one request per cycle while out_stall is low.
// Reset clears both matrices, the queue and all valid flags.
// When the receiver stalls, the result holds, the pipeline fills, and the input
// stall rises once the queue is full; loads are then held too.
`default_nettype none
module affine_vector_and_box_transform_top #(
  parameter int FRAC_BITS = avbt_pkg::FRAC_BITS_DEF
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  input  avbt_pkg::in_t   in_data,
  output logic            out_valid,
  input  wire             out_stall,
  output avbt_pkg::out_t  out_data
);
  import avbt_pkg::*;

  job_t fj, bj;
  logic fv, fs, bv, bs;

  avbt_front u_front (.clk, .rst, .valid(in_valid), .stall(in_stall), .data(in_data),
    .job_valid(fv), .job_stall(fs), .job(fj));
  avbt_queue u_queue (.clk, .rst, .in_valid(fv), .in_stall(fs), .in_job(fj),
    .out_valid(bv), .out_stall(bs), .out_job(bj));
  avbt_back #(.FRAC_BITS(FRAC_BITS)) u_back (.clk, .rst, .job_valid(bv), .job_stall(bs),
    .job(bj), .valid(out_valid), .stall(out_stall), .data(out_data));
endmodule
`default_nettype wire

// File: rtl/avbt_checker.sv
// Port-level checker for the transform top level, bound to it below.
// Depends on avbt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module avbt_checker (
  input wire            clk,
  input wire            rst,
  input wire            in_valid,
  input wire            in_stall,
  input avbt_pkg::in_t  in_data,
  input wire            out_valid,
  input wire            out_stall,
  input avbt_pkg::out_t out_data
);
  `CHK_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "result dropped")
  `CHK_IMPL(a_stall_cause, clk, rst, in_stall, out_valid, "input stall without a waiting result")
  `CHK_IMPL(a_ctrl_known, clk, rst, 1'b1, !$isunknown({out_valid, in_stall}), "unknown control")
  `CHK_IMPL(a_data_known, clk, rst, out_valid, !$isunknown(out_data), "unknown result")
endmodule
bind affine_vector_and_box_transform_top avbt_checker u_chk (.*);
`default_nettype wire
